// ----- hw/rtl/gtpa_pkg.sv -----
// gtpa_pkg: shared types and constants for the gated temporal pixel average
// used by every module under hw/rtl; depends on nothing
package gtpa_pkg;

    localparam int unsigned PIX_W       = 8;
    localparam int unsigned SUM_W       = 12;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned NUM_CH      = 3;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned DIV_STEPS   = SUM_W;

    localparam logic [PIX_W-1:0] THR_RESET = 8'd40;
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [PIX_W-1:0] PIX_MAX   = {PIX_W{1'b1}};

    // one classified item as it waits between front and back
    typedef struct packed {
        logic                       start;
        logic                       take;
        logic                       last;
        logic [NUM_CH-1:0][PIX_W-1:0] ref_px;
        logic [NUM_CH-1:0][PIX_W-1:0] cand_px;
    } t_item;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [1:0] {
        BS_RUN,
        BS_DIV,
        BS_OUT
    } t_bstate;

endpackage

// ----- hw/rtl/gtpa_front.sv -----
// gtpa_front: takes input transfers, holds the threshold register and tests the neighbour
// depends on gtpa_pkg
module gtpa_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [7:0]             i_cfg_wdata,
    input  logic                   i_valid,
    input  logic                   i_start_req,
    input  logic [7:0]             i_ref_c0,
    input  logic [7:0]             i_ref_c1,
    input  logic [7:0]             i_ref_c2,
    input  logic [7:0]             i_cand_c0,
    input  logic [7:0]             i_cand_c1,
    input  logic [7:0]             i_cand_c2,
    input  logic                   i_cand_valid,
    input  logic                   i_last,
    input  gtpa_pkg::t_qstat       i_qstat,
    output logic                   o_stall,
    output logic                   o_push,
    output gtpa_pkg::t_item        o_item
);
    import gtpa_pkg::*;

    logic [PIX_W-1:0] r_thr;
    logic [PIX_W-1:0] d0, d1, d2;
    logic [PIX_W+1:0] wsum;
    logic [PIX_W-1:0] wdiff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    assign d0 = (i_ref_c0 >= i_cand_c0) ? i_ref_c0 - i_cand_c0 : i_cand_c0 - i_ref_c0;
    assign d1 = (i_ref_c1 >= i_cand_c1) ? i_ref_c1 - i_cand_c1 : i_cand_c1 - i_ref_c1;
    assign d2 = (i_ref_c2 >= i_cand_c2) ? i_ref_c2 - i_cand_c2 : i_cand_c2 - i_ref_c2;

    // channel 1 counts twice, then divide by four
    assign wsum  = {2'b00, d0} + {1'b0, d1, 1'b0} + {2'b00, d2};
    assign wdiff = wsum[PIX_W+1:2];

    assign o_stall = i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    always_comb begin
        o_item.start      = i_start_req;
        o_item.take       = i_cand_valid && (wdiff <= r_thr);
        o_item.last       = i_last;
        o_item.ref_px[0]  = i_ref_c0;
        o_item.ref_px[1]  = i_ref_c1;
        o_item.ref_px[2]  = i_ref_c2;
        o_item.cand_px[0] = i_cand_c0;
        o_item.cand_px[1] = i_cand_c1;
        o_item.cand_px[2] = i_cand_c2;
    end

endmodule

// ----- hw/rtl/gtpa_queue.sv -----
// gtpa_queue: short flip-flop queue of classified items between front and back
// depends on gtpa_pkg
module gtpa_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gtpa_pkg::t_item    i_item,
    input  logic               i_pop,
    output gtpa_pkg::t_item    o_head,
    output gtpa_pkg::t_qstat   o_qstat
);
    import gtpa_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_item              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_QW-1:0]  r_fill, n_fill;
    logic               do_push, do_pop;

    assign o_qstat.full  = (r_fill == CNT_QW'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_fill == '0);
    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_head  = r_slot[r_rptr];

    always_comb begin
        n_wptr = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = do_pop  ? r_rptr + 1'b1 : r_rptr;
        n_fill = r_fill;
        if (do_push && !do_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

endmodule

// ----- hw/rtl/gtpa_back.sv -----
// gtpa_back: accumulates queued items into the channel sums and divides on last
// depends on gtpa_pkg
module gtpa_back #(
    parameter int unsigned NEIGHBOURS_PER_SIDE = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gtpa_pkg::t_item    i_head,
    input  gtpa_pkg::t_qstat   i_qstat,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [7:0]         o_out_c0,
    output logic [7:0]         o_out_c1,
    output logic [7:0]         o_out_c2
);
    import gtpa_pkg::*;

    localparam int unsigned LIM_RAW = 2 * NEIGHBOURS_PER_SIDE + 1;
    localparam logic [CNT_W-1:0] CNT_LIMIT =
        (LIM_RAW > 15) ? CNT_MAX : CNT_W'(LIM_RAW);
    localparam int unsigned ITER_W = $clog2(DIV_STEPS);

    t_bstate            r_state, n_state;
    logic [SUM_W-1:0]   r_sum [NUM_CH];
    logic [SUM_W-1:0]   n_sum [NUM_CH];
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [SUM_W-1:0]   r_quo [NUM_CH];
    logic [SUM_W-1:0]   n_quo [NUM_CH];
    logic [CNT_W-1:0]   r_rem [NUM_CH];
    logic [CNT_W-1:0]   n_rem [NUM_CH];
    logic [ITER_W-1:0]  r_iter, n_iter;

    logic [SUM_W-1:0]   acc_sum [NUM_CH];
    logic [CNT_W-1:0]   acc_cnt;
    logic [SUM_W:0]     wide_sum [NUM_CH];
    logic [CNT_W:0]     trial [NUM_CH];
    logic               add_ok;

    // start loads, then the gated neighbour adds with saturation
    always_comb begin
        add_ok  = i_head.take && ((i_head.start ? 4'd1 : r_cnt) < CNT_LIMIT);
        acc_cnt = i_head.start ? CNT_W'(1) : r_cnt;
        if (add_ok) begin
            acc_cnt = acc_cnt + 1'b1;
        end
        for (int k = 0; k < NUM_CH; k++) begin
            acc_sum[k]  = i_head.start ? {{(SUM_W-PIX_W){1'b0}}, i_head.ref_px[k]} : r_sum[k];
            wide_sum[k] = {1'b0, acc_sum[k]} + {{(SUM_W-PIX_W+1){1'b0}}, i_head.cand_px[k]};
            if (add_ok) begin
                acc_sum[k] = wide_sum[k][SUM_W] ? SUM_MAX : wide_sum[k][SUM_W-1:0];
            end
        end
    end

    // restoring division, one quotient bit per cycle on all three channels
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            trial[k] = {r_rem[k], r_quo[k][SUM_W-1]};
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_iter  = r_iter;
        o_pop   = 1'b0;
        for (int k = 0; k < NUM_CH; k++) begin
            n_sum[k] = r_sum[k];
            n_quo[k] = r_quo[k];
            n_rem[k] = r_rem[k];
        end
        unique case (r_state)
            BS_RUN: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    n_cnt = acc_cnt;
                    for (int k = 0; k < NUM_CH; k++) begin
                        n_sum[k] = acc_sum[k];
                        n_quo[k] = acc_sum[k];
                        n_rem[k] = '0;
                    end
                    n_iter = '0;
                    if (i_head.last) begin
                        n_state = BS_DIV;
                    end
                end
            end
            BS_DIV: begin
                for (int k = 0; k < NUM_CH; k++) begin
                    if (trial[k] >= {1'b0, r_cnt}) begin
                        n_rem[k] = CNT_W'(trial[k] - {1'b0, r_cnt});
                        n_quo[k] = {r_quo[k][SUM_W-2:0], 1'b1};
                    end else begin
                        n_rem[k] = trial[k][CNT_W-1:0];
                        n_quo[k] = {r_quo[k][SUM_W-2:0], 1'b0};
                    end
                end
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_W'(DIV_STEPS - 1)) begin
                    n_state = BS_OUT;
                end
            end
            BS_OUT: begin
                if (!i_stall) begin
                    n_state = BS_RUN;
                end
            end
            default: n_state = BS_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_RUN;
            r_cnt   <= CNT_W'(1);
            for (int k = 0; k < NUM_CH; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            for (int k = 0; k < NUM_CH; k++) begin
                r_sum[k] <= n_sum[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_iter <= n_iter;
        for (int k = 0; k < NUM_CH; k++) begin
            r_quo[k] <= n_quo[k];
            r_rem[k] <= n_rem[k];
        end
    end

    // quotient saturates at full scale
    assign o_valid  = (r_state == BS_OUT);
    assign o_out_c0 = (|r_quo[0][SUM_W-1:PIX_W]) ? PIX_MAX : r_quo[0][PIX_W-1:0];
    assign o_out_c1 = (|r_quo[1][SUM_W-1:PIX_W]) ? PIX_MAX : r_quo[1][PIX_W-1:0];
    assign o_out_c2 = (|r_quo[2][SUM_W-1:PIX_W]) ? PIX_MAX : r_quo[2][PIX_W-1:0];

endmodule

// ----- hw/rtl/gated_temporal_pixel_average.sv -----
// gated_temporal_pixel_average: top level joining front, queue and back
// depends on gtpa_pkg, gtpa_front, gtpa_queue, gtpa_back
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_start_req, i_ref_c0..2, i_cand_c0..2,
//                                           i_cand_valid, i_last
//  output    out        o_valid / i_stall   o_out_c0..2
//  config    in         i_cfg_we            i_cfg_wdata (diff threshold)
//
// the front tests each neighbour as it is taken and queues it (4 entries)
// the back folds one queued item per cycle into the sums while it is in its run state
// a last item sends the back through the bit-serial divider and then into its output state
// while the back divides or holds a stalled result, the queue keeps taking items until it is full
// synchronous active-low reset: sums 0, count 1, threshold 40, queue empty
module gated_temporal_pixel_average #(
    parameter int unsigned NEIGHBOURS_PER_SIDE = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_start_req,
    input  logic [7:0] i_ref_c0,
    input  logic [7:0] i_ref_c1,
    input  logic [7:0] i_ref_c2,
    input  logic [7:0] i_cand_c0,
    input  logic [7:0] i_cand_c1,
    input  logic [7:0] i_cand_c2,
    input  logic       i_cand_valid,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_c0,
    output logic [7:0] o_out_c1,
    output logic [7:0] o_out_c2
);
    import gtpa_pkg::*;

    t_item  push_item;
    t_item  head_item;
    t_qstat qstat;
    logic   push;
    logic   pop;

    gtpa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .i_start_req  (i_start_req),
        .i_ref_c0     (i_ref_c0),
        .i_ref_c1     (i_ref_c1),
        .i_ref_c2     (i_ref_c2),
        .i_cand_c0    (i_cand_c0),
        .i_cand_c1    (i_cand_c1),
        .i_cand_c2    (i_cand_c2),
        .i_cand_valid (i_cand_valid),
        .i_last       (i_last),
        .i_qstat      (qstat),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_item       (push_item)
    );

    gtpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_qstat (qstat)
    );

    gtpa_back #(
        .NEIGHBOURS_PER_SIDE (NEIGHBOURS_PER_SIDE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_item),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_out_c0 (o_out_c0),
        .o_out_c1 (o_out_c1),
        .o_out_c2 (o_out_c2)
    );

endmodule
